// File: hw/rtl/ilbmdec_pkg.sv
// ilbmdec_pkg: tags, control codes and result kinds of the ilbm byterun1 decoder
// no dependencies; imported by the decoder top level and its checker

package ilbmdec_pkg;

  // chunk and form tags, big-endian ascii
  localparam logic [31:0] TAG_FORM = 32'h464F_524D;
  localparam logic [31:0] TAG_ILBM = 32'h494C_424D;
  localparam logic [31:0] TAG_BMHD = 32'h424D_4844;
  localparam logic [31:0] TAG_BODY = 32'h424F_4459;
  localparam logic [31:0] TAG_CMAP = 32'h434D_4150;

  // byterun1 no-op control byte
  localparam logic [7:0] RUN_NOP = 8'h80;

  // highest field offset tracked inside a chunk
  localparam logic [4:0] FIELD_CNT_MAX = 5'd31;

  // bitmap header field offsets
  localparam logic [4:0] BMHD_W_HI   = 5'd0;
  localparam logic [4:0] BMHD_W_LO   = 5'd1;
  localparam logic [4:0] BMHD_H_HI   = 5'd2;
  localparam logic [4:0] BMHD_H_LO   = 5'd3;
  localparam logic [4:0] BMHD_PLANES = 5'd8;
  localparam logic [4:0] BMHD_MASK   = 5'd9;
  localparam logic [4:0] BMHD_COMP   = 5'd10;

  // result kinds, sent on the result tuser
  typedef enum logic [2:0] {
    KIND_RUN      = 3'd0,
    KIND_PALETTE  = 3'd1,
    KIND_HEADER   = 3'd2,
    KIND_BAD_FORM = 3'd3,
    KIND_BAD_ILBM = 3'd4,
    KIND_DONE     = 3'd5,
    KIND_OVERRUN  = 3'd6
  } kind_t;

endpackage

// File: hw/rtl/ilbm_byterun1_stream_decoder.sv
// ilbm_byterun1_stream_decoder: iff ilbm parser with byterun1 body unpacking
// depends on ilbmdec_pkg (tags, codes, result kinds)
//
// usage
//   input channel in_*: one file byte per transfer, in file order
//   result channel out_*: at most one result per input byte; out_tuser is the
//     result kind (run, palette entry, header, bad form, bad ilbm, done,
//     clipped run), out_tdata carries address, value, run length and the
//     bitmap header fields, zero where they mean nothing for the kind
//   output: a result is registered and is on out_* in the cycle after the byte that causes it
//   throughput: one byte per cycle when not stalled; every byte is handled by
//     one pass of per-phase logic between the parser state and the result
//     register, with run addresses kept as running sums (one add per byte)
//   stall: the result register parts the channels; in_tready stays high while
//     the result register is empty or being taken, and drops only while a
//     result waits on a low out_tready
//   reset: a synchronous low rst_n returns the parser to expecting the form
//     tag and empties the result register; no clearing pass is needed
//   after a bad tag or the done report all further bytes are taken and dropped
//   until the next reset
//   ADDR_BITS sets the width of the run address arithmetic; addresses wrap at
//     2**ADDR_BITS and the low 20 bits are reported

module ilbm_byterun1_stream_decoder
  import ilbmdec_pkg::*;
#(
  parameter int ADDR_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [19:0] address, [31:20] value, [39:32] run_length,
                                  // [55:40] image_width, [71:56] image_height,
                                  // [79:72] plane_count, [87:80] mask_mode,
                                  // [95:88] compression_mode
  output logic [2:0]  out_tuser   // [2:0] kind
);

  localparam int AW = ADDR_BITS;

  // parser phases
  typedef enum logic [4:0] {
    PH_FORM, PH_FSIZE, PH_ILBM, PH_CHID,
    PH_SZ_BMHD, PH_SZ_BODY, PH_SZ_CMAP, PH_SZ_OTHER,
    PH_BMHD, PH_BODY_CTRL, PH_BODY_LIT, PH_BODY_REP, PH_CMAP, PH_SKIP,
    PH_PAD, PH_DONE_PEND, PH_IDLE
  } phase_t;

  // parser state
  phase_t        phase_r,      phase_nxt;
  logic [31:0]   shift_r,      shift_nxt;      // tag / size collector
  logic [4:0]    fcnt_r,       fcnt_nxt;       // byte count within field or chunk
  logic [31:0]   file_rem_r,   file_rem_nxt;
  logic [31:0]   chunk_rem_r,  chunk_rem_nxt;
  logic          chunk_pad_r,  chunk_pad_nxt;
  logic [15:0]   hdr_width_r,  hdr_width_nxt;
  logic [15:0]   hdr_height_r, hdr_height_nxt;
  logic [7:0]    hdr_planes_r, hdr_planes_nxt;
  logic [7:0]    hdr_mask_r,   hdr_mask_nxt;
  logic [7:0]    hdr_comp_r,   hdr_comp_nxt;
  logic [13:0]   row_bytes_r,  row_bytes_nxt;
  logic [15:0]   row_idx_r,    row_idx_nxt;
  logic [7:0]    plane_idx_r,  plane_idx_nxt;
  logic [12:0]   col_idx_r,    col_idx_nxt;
  logic [AW-1:0] row_base_r,   row_base_nxt;   // plane*stride + row*row_bytes
  logic [AW-1:0] row_start_r,  row_start_nxt;  // row*row_bytes
  logic [AW-1:0] stride_r;                     // row_bytes*height, one plane
  logic [7:0]    pkt_cnt_r,    pkt_cnt_nxt;
  logic [7:0]    colour_r,     colour_nxt;
  logic [7:0]    pal_idx_r,    pal_idx_nxt;

  // result register
  logic          out_valid_r,  out_valid_nxt;
  kind_t         out_kind_r;
  logic [19:0]   out_addr_r;
  logic [11:0]   out_value_r;
  logic [7:0]    out_len_r;
  logic [15:0]   out_width_r;
  logic [15:0]   out_height_r;
  logic [7:0]    out_planes_r;
  logic [7:0]    out_mask_r;
  logic [7:0]    out_comp_r;

  // result of the current byte
  logic          em;
  kind_t         em_kind;
  logic [19:0]   em_addr;
  logic [11:0]   em_value;
  logic [7:0]    em_len;
  logic          em_hdr;

  logic          in_fire;
  logic [7:0]    in_byte;
  logic [31:0]   shift_cat;
  logic          field_done;
  logic [4:0]    fcnt_inc;
  logic [31:0]   file_dec;
  logic [16:0]   width_sum;
  logic [13:0]   rb_new;
  logic          image_done;
  logic [AW-1:0] cur_addr;
  logic [13:0]   room;
  logic          clip;
  logic [7:0]    rep_len;
  logic [7:0]    adv_len;
  logic          adv;
  logic [13:0]   col_sum;
  logic [7:0]    plane_inc;
  logic [3:0]    nib;
  logic          data_end_req;
  logic          chunk_end_req;
  logic [29:0]   stride_prod;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign in_byte    = in_tdata;

  assign shift_cat  = {shift_r[23:0], in_byte};
  assign field_done = (fcnt_r >= 5'd3);
  assign fcnt_inc   = fcnt_r + 5'd1;
  assign file_dec   = (file_rem_r != 32'd0) ? file_rem_r - 32'd1 : file_rem_r;
  assign nib        = in_byte[7:4];

  // bytes per plane row: width rounded up to 16 pixels, in bytes
  assign width_sum  = {1'b0, hdr_width_r} + 17'd15;
  assign rb_new     = {width_sum[16:4], 1'b0};

  assign image_done = (hdr_planes_r == 8'd0) || (hdr_height_r == 16'd0) ||
                      (row_bytes_r == 14'd0) || (row_idx_r >= hdr_height_r);

  assign cur_addr   = row_base_r + AW'(col_idx_r);

  // repeat run clipped to the end of the current row
  assign room       = row_bytes_r - {1'b0, col_idx_r};
  assign clip       = {6'd0, pkt_cnt_r} > room;
  assign rep_len    = clip ? room[7:0] : pkt_cnt_r;

  assign col_sum    = {1'b0, col_idx_r} + {6'd0, adv_len};
  assign plane_inc  = plane_idx_r + 8'd1;

  // one plane's size, registered ahead of the first run of a body
  assign stride_prod = 30'(row_bytes_r) * 30'(hdr_height_r);

  always_comb begin
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    fcnt_nxt       = fcnt_r;
    file_rem_nxt   = file_rem_r;
    chunk_rem_nxt  = chunk_rem_r;
    chunk_pad_nxt  = chunk_pad_r;
    hdr_width_nxt  = hdr_width_r;
    hdr_height_nxt = hdr_height_r;
    hdr_planes_nxt = hdr_planes_r;
    hdr_mask_nxt   = hdr_mask_r;
    hdr_comp_nxt   = hdr_comp_r;
    row_bytes_nxt  = row_bytes_r;
    row_idx_nxt    = row_idx_r;
    plane_idx_nxt  = plane_idx_r;
    col_idx_nxt    = col_idx_r;
    row_base_nxt   = row_base_r;
    row_start_nxt  = row_start_r;
    pkt_cnt_nxt    = pkt_cnt_r;
    colour_nxt     = colour_r;
    pal_idx_nxt    = pal_idx_r;
    em             = 1'b0;
    em_kind        = KIND_RUN;
    em_addr        = 20'd0;
    em_value       = 12'd0;
    em_len         = 8'd0;
    em_hdr         = 1'b0;
    adv            = 1'b0;
    adv_len        = 8'd0;
    data_end_req   = 1'b0;
    chunk_end_req  = 1'b0;

    if (in_fire) begin
      case (phase_r)
        PH_FORM: begin
          shift_nxt = shift_cat;
          fcnt_nxt  = field_done ? 5'd0 : fcnt_inc;
          if (field_done) begin
            if (shift_cat != TAG_FORM) begin
              phase_nxt = PH_IDLE;
              em        = 1'b1;
              em_kind   = KIND_BAD_FORM;
            end else begin
              phase_nxt = PH_FSIZE;
            end
          end
        end
        PH_FSIZE: begin
          shift_nxt = shift_cat;
          fcnt_nxt  = field_done ? 5'd0 : fcnt_inc;
          if (field_done) begin
            file_rem_nxt = shift_cat;
            phase_nxt    = PH_ILBM;
          end
        end
        PH_ILBM: begin
          shift_nxt = shift_cat;
          fcnt_nxt  = field_done ? 5'd0 : fcnt_inc;
          if (field_done) begin
            if (shift_cat != TAG_ILBM) begin
              phase_nxt = PH_IDLE;
              em        = 1'b1;
              em_kind   = KIND_BAD_ILBM;
            end else begin
              // the form type tag counts against the form size
              file_rem_nxt  = (file_rem_r > 32'd4) ? file_rem_r - 32'd4 : 32'd0;
              chunk_end_req = 1'b1;
            end
          end
        end
        PH_CHID: begin
          file_rem_nxt = file_dec;
          shift_nxt    = shift_cat;
          fcnt_nxt     = field_done ? 5'd0 : fcnt_inc;
          if (field_done) begin
            if (shift_cat == TAG_BMHD) begin
              phase_nxt = PH_SZ_BMHD;
            end else if (shift_cat == TAG_BODY) begin
              phase_nxt = PH_SZ_BODY;
            end else if (shift_cat == TAG_CMAP) begin
              phase_nxt = PH_SZ_CMAP;
            end else begin
              phase_nxt = PH_SZ_OTHER;
            end
          end
        end
        PH_SZ_BMHD, PH_SZ_BODY, PH_SZ_CMAP, PH_SZ_OTHER: begin
          file_rem_nxt = file_dec;
          shift_nxt    = shift_cat;
          fcnt_nxt     = field_done ? 5'd0 : fcnt_inc;
          if (field_done) begin
            chunk_rem_nxt = shift_cat;
            chunk_pad_nxt = shift_cat[0];
            case (phase_r)
              PH_SZ_BMHD:  phase_nxt = PH_BMHD;
              PH_SZ_CMAP:  phase_nxt = PH_CMAP;
              PH_SZ_OTHER: phase_nxt = PH_SKIP;
              default: begin
                // body start: new geometry, write position back to zero
                row_bytes_nxt = rb_new;
                row_idx_nxt   = 16'd0;
                plane_idx_nxt = 8'd0;
                col_idx_nxt   = 13'd0;
                row_base_nxt  = '0;
                row_start_nxt = '0;
                pkt_cnt_nxt   = 8'd0;
                phase_nxt     = PH_BODY_CTRL;
              end
            endcase
            data_end_req = (shift_cat == 32'd0);
          end
        end
        PH_BMHD, PH_BODY_CTRL, PH_BODY_LIT, PH_BODY_REP, PH_CMAP, PH_SKIP: begin
          file_rem_nxt  = file_dec;
          chunk_rem_nxt = chunk_rem_r - 32'd1;
          data_end_req  = (chunk_rem_r == 32'd1);
          case (phase_r)
            PH_BMHD: begin
              case (fcnt_r)
                BMHD_W_HI:   hdr_width_nxt[15:8]  = in_byte;
                BMHD_W_LO:   hdr_width_nxt[7:0]   = in_byte;
                BMHD_H_HI:   hdr_height_nxt[15:8] = in_byte;
                BMHD_H_LO:   hdr_height_nxt[7:0]  = in_byte;
                BMHD_PLANES: hdr_planes_nxt       = in_byte;
                BMHD_MASK:   hdr_mask_nxt         = in_byte;
                BMHD_COMP: begin
                  hdr_comp_nxt = in_byte;
                  em           = 1'b1;
                  em_kind      = KIND_HEADER;
                  em_hdr       = 1'b1;
                end
                default: ;
              endcase
              if (fcnt_r < FIELD_CNT_MAX) begin
                fcnt_nxt = fcnt_inc;
              end
            end
            PH_CMAP: begin
              // r, g, b bytes; high nibble of each kept
              case (fcnt_r)
                5'd0: begin
                  colour_nxt = {nib, 4'd0};
                  fcnt_nxt   = 5'd1;
                end
                5'd1: begin
                  colour_nxt = colour_r | {4'd0, nib};
                  fcnt_nxt   = 5'd2;
                end
                default: begin
                  em          = 1'b1;
                  em_kind     = KIND_PALETTE;
                  em_addr     = {12'd0, pal_idx_r};
                  em_value    = {colour_r, nib};
                  pal_idx_nxt = pal_idx_r + 8'd1;
                  fcnt_nxt    = 5'd0;
                end
              endcase
            end
            PH_BODY_CTRL: begin
              if (!image_done && in_byte != RUN_NOP) begin
                if (in_byte[7]) begin
                  pkt_cnt_nxt = 8'(9'd257 - {1'b0, in_byte});
                  phase_nxt   = PH_BODY_REP;
                end else begin
                  pkt_cnt_nxt = in_byte + 8'd1;
                  phase_nxt   = PH_BODY_LIT;
                end
              end
            end
            PH_BODY_LIT: begin
              if (!image_done) begin
                em       = 1'b1;
                em_kind  = KIND_RUN;
                em_addr  = 20'(cur_addr);
                em_value = {4'd0, in_byte};
                em_len   = 8'd1;
                adv      = 1'b1;
                adv_len  = 8'd1;
                if (pkt_cnt_r != 8'd0) begin
                  pkt_cnt_nxt = pkt_cnt_r - 8'd1;
                end
                if (pkt_cnt_r <= 8'd1) begin
                  phase_nxt = PH_BODY_CTRL;
                end
              end
            end
            PH_BODY_REP: begin
              if (!image_done) begin
                em        = 1'b1;
                em_kind   = clip ? KIND_OVERRUN : KIND_RUN;
                em_addr   = 20'(cur_addr);
                em_value  = {4'd0, in_byte};
                em_len    = rep_len;
                adv       = 1'b1;
                adv_len   = rep_len;
                phase_nxt = PH_BODY_CTRL;
              end
            end
            default: ;  // skipped chunk
          endcase
        end
        PH_PAD: begin
          file_rem_nxt  = file_dec;
          chunk_end_req = 1'b1;
        end
        PH_DONE_PEND: begin
          phase_nxt = PH_IDLE;
          em        = 1'b1;
          em_kind   = KIND_DONE;
        end
        default: ;  // idle after error or done
      endcase

      // write position: next column, next plane row, or next image row
      if (adv) begin
        if (col_sum >= row_bytes_r) begin
          col_idx_nxt = 13'd0;
          if (plane_inc >= hdr_planes_r) begin
            plane_idx_nxt = 8'd0;
            row_idx_nxt   = row_idx_r + 16'd1;
            row_start_nxt = row_start_r + AW'(row_bytes_r);
            row_base_nxt  = row_start_nxt;
          end else begin
            plane_idx_nxt = plane_inc;
            row_base_nxt  = row_base_r + stride_r;
          end
        end else begin
          col_idx_nxt = col_sum[12:0];
        end
      end

      // end of chunk data: pad byte, next chunk or end of file
      if (data_end_req && chunk_pad_nxt) begin
        phase_nxt = PH_PAD;
      end else if (data_end_req || chunk_end_req) begin
        if (file_rem_nxt > 32'd8) begin
          phase_nxt = PH_CHID;
          fcnt_nxt  = 5'd0;
        end else if (em) begin
          phase_nxt = PH_DONE_PEND;
        end else begin
          phase_nxt = PH_IDLE;
          em        = 1'b1;
          em_kind   = KIND_DONE;
        end
      end
    end

    // result register: loaded on a transfer in, emptied when taken
    if (in_fire) begin
      out_valid_nxt = em;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FORM;
      shift_r      <= 32'd0;
      fcnt_r       <= 5'd0;
      file_rem_r   <= 32'd0;
      chunk_rem_r  <= 32'd0;
      chunk_pad_r  <= 1'b0;
      hdr_width_r  <= 16'd0;
      hdr_height_r <= 16'd0;
      hdr_planes_r <= 8'd0;
      hdr_mask_r   <= 8'd0;
      hdr_comp_r   <= 8'd0;
      row_bytes_r  <= 14'd0;
      row_idx_r    <= 16'd0;
      plane_idx_r  <= 8'd0;
      col_idx_r    <= 13'd0;
      row_base_r   <= '0;
      row_start_r  <= '0;
      pkt_cnt_r    <= 8'd0;
      colour_r     <= 8'd0;
      pal_idx_r    <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      fcnt_r       <= fcnt_nxt;
      file_rem_r   <= file_rem_nxt;
      chunk_rem_r  <= chunk_rem_nxt;
      chunk_pad_r  <= chunk_pad_nxt;
      hdr_width_r  <= hdr_width_nxt;
      hdr_height_r <= hdr_height_nxt;
      hdr_planes_r <= hdr_planes_nxt;
      hdr_mask_r   <= hdr_mask_nxt;
      hdr_comp_r   <= hdr_comp_nxt;
      row_bytes_r  <= row_bytes_nxt;
      row_idx_r    <= row_idx_nxt;
      plane_idx_r  <= plane_idx_nxt;
      col_idx_r    <= col_idx_nxt;
      row_base_r   <= row_base_nxt;
      row_start_r  <= row_start_nxt;
      pkt_cnt_r    <= pkt_cnt_nxt;
      colour_r     <= colour_nxt;
      pal_idx_r    <= pal_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      stride_r     <= AW'(stride_prod);
      if (in_fire && em) begin
        out_kind_r   <= em_kind;
        out_addr_r   <= em_addr;
        out_value_r  <= em_value;
        out_len_r    <= em_len;
        out_width_r  <= em_hdr ? hdr_width_nxt  : 16'd0;
        out_height_r <= em_hdr ? hdr_height_nxt : 16'd0;
        out_planes_r <= em_hdr ? hdr_planes_nxt : 8'd0;
        out_mask_r   <= em_hdr ? hdr_mask_nxt   : 8'd0;
        out_comp_r   <= em_hdr ? hdr_comp_nxt   : 8'd0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_comp_r, out_mask_r, out_planes_r, out_height_r, out_width_r,
                       out_len_r, out_value_r, out_addr_r};

endmodule

// File: hw/rtl/ilbmdec_checker.sv
// ilbmdec_checker: port-level assertions for the ilbm byterun1 decoder
// depends on ilbmdec_pkg; bound to ilbm_byterun1_stream_decoder below

module ilbmdec_checker
  import ilbmdec_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result pending after reset");

  // an empty result register never holds back input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // run transfers carry a length of 1 to 128
  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RUN || out_tuser == KIND_OVERRUN)
      |-> out_tdata[39:32] != 8'd0 && out_tdata[39:32] <= 8'd128)
    else $error("run length out of range");

  // status results carry an all-zero payload
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DONE || out_tuser == KIND_BAD_FORM ||
                   out_tuser == KIND_BAD_ILBM) |-> out_tdata == 96'd0)
    else $error("status result with nonzero payload");

endmodule

bind ilbm_byterun1_stream_decoder ilbmdec_checker u_ilbmdec_checker (.*);
